// ----- sv/serial_command_line_parser_core_macros.svh -----
// Assertion macros for the serial command line parser checker.
// Depends on nothing; include it by its bare file name.
`ifndef SERIAL_COMMAND_LINE_PARSER_CORE_MACROS_SVH
`define SERIAL_COMMAND_LINE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/sclp_pkg.sv -----
// Package for the serial command line parser: types, codes and helpers.
// Used by the controller, the datapath and the top level.
`default_nettype none

package sclp_pkg;

   // Default sizes of the line buffer and the message store.
   localparam int LINE_CHARS_DEF = 63;
   localparam int MSG_CHARS_DEF  = 31;

   // Character codes the parser looks for.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Saturation limit of the magnitude and the largest positive value.
   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

   // Parse phase of the current line.
   typedef enum logic [2:0] {
      PH_PREFIX = 3'd0,
      PH_BLANKS = 3'd1,
      PH_SIGN   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_MSG    = 3'd4,
      PH_FAIL   = 3'd5
   } phase_type;

   // Controller states.
   typedef enum logic {
      CTRL_IDLE  = 1'b0,
      CTRL_DRAIN = 1'b1
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic byte_en;
      logic load_out;
      logic clear_line;
   } sclp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic term;
      logic line_empty;
      logic drain_last;
   } sclp_status_type;

   // Characters of the "SET:" prefix by position.
   function automatic logic [7:0] set_prefix_char(input logic [1:0] pos);
      logic [7:0] ch;
      unique case (pos)
         2'd0:    ch = 8'h53;
         2'd1:    ch = 8'h45;
         2'd2:    ch = 8'h54;
         default: ch = 8'h3A;
      endcase
      return ch;
   endfunction

   function automatic logic is_blank(input logic [7:0] ch);
      return (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0B) || (ch == 8'h0C);
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= 8'h30) && (ch <= 8'h39);
   endfunction

endpackage

`default_nettype wire

// ----- sv/sclp_ctrl.sv -----
// Controller of the serial command line parser: input acceptance and result drain.
// Depends on sclp_pkg.
`default_nettype none

module sclp_ctrl
   import sclp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire sclp_status_type status,
   output sclp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // State and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The output register can take a new item when empty or being emptied.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (!status.term) begin
                  cmd.byte_en = 1'b1;
               end else if (!status.line_empty) begin
                  state_in = CTRL_DRAIN;
               end
            end
         end
         CTRL_DRAIN: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               if (status.drain_last) begin
                  cmd.clear_line = 1'b1;
                  state_in       = CTRL_IDLE;
               end
            end
         end
         default: state_in = CTRL_IDLE;
      endcase
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   end

endmodule

`default_nettype wire

// ----- sv/sclp_datapath.sv -----
// Datapath of the serial command line parser: line parse state, message store
// and result register. Depends on sclp_pkg.
`default_nettype none

module sclp_datapath
   import sclp_pkg::*;
#(
   parameter int LINE_CHARS = LINE_CHARS_DEF,
   parameter int MSG_CHARS  = MSG_CHARS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic        [7:0]  req_rx_byte,
   input  wire sclp_cmd_type       cmd,
   output sclp_status_type         status,
   output logic                    rsp_ok,
   output logic signed      [31:0] rsp_value,
   output logic             [7:0]  rsp_msg_char,
   output logic                    rsp_last
);

   localparam int CNT_W = $clog2(LINE_CHARS + 1);
   localparam int LEN_W = $clog2(MSG_CHARS + 1);
   localparam int IDX_W = (MSG_CHARS > 1) ? $clog2(MSG_CHARS) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   phase_type        phase_ff, phase_in;
   logic             set_form_ff, set_form_in;
   logic             neg_ff, neg_in;
   logic [31:0]      acc_ff, acc_in;
   logic             text_ended_ff, text_ended_in;
   logic [LEN_W-1:0] msg_len_ff, msg_len_in;
   logic [IDX_W-1:0] drain_idx_ff, drain_idx_in;

   logic [7:0]       msg_mem [MSG_CHARS];
   logic             mem_we;

   logic             rsp_ok_ff;
   logic [31:0]      rsp_value_ff;
   logic [7:0]       rsp_msg_char_ff;
   logic             rsp_last_ff;

   logic [35:0]      acc_prod;
   logic [31:0]      acc_step;
   logic [31:0]      acc_first;
   logic [7:0]       sep_char;
   logic             as_blanks;
   logic             line_ok;
   logic [31:0]      line_value;

   // One decimal step of the saturated magnitude: acc * 10 + digit.
   assign acc_prod  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                      + {32'b0, req_rx_byte[3:0]};
   assign acc_step  = (acc_prod > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : acc_prod[31:0];
   assign acc_first = {28'b0, req_rx_byte[3:0]};
   assign sep_char  = set_form_ff ? CHAR_COLON : CHAR_COMMA;

   // Verdict and value of the finished line.
   assign line_ok    = (phase_ff == PH_MSG) && (msg_len_ff != '0);
   assign line_value = neg_ff ? (32'd0 - acc_ff) : (acc_ff[31] ? POS_MAX : acc_ff);

   // Status toward the controller.
   assign status.term       = (req_rx_byte == CHAR_LF) || (req_rx_byte == CHAR_CR);
   assign status.line_empty = (count_ff == '0);
   assign status.drain_last = !line_ok
                              || ((LEN_W'(drain_idx_ff) + LEN_W'(1)) == msg_len_ff);

   // Parse of one received byte, drain index and line clear.
   always_comb begin
      count_in      = count_ff;
      phase_in      = phase_ff;
      set_form_in   = set_form_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      text_ended_in = text_ended_ff;
      msg_len_in    = msg_len_ff;
      drain_idx_in  = drain_idx_ff;
      mem_we        = 1'b0;
      as_blanks     = 1'b0;
      if (cmd.clear_line) begin
         count_in      = '0;
         phase_in      = PH_PREFIX;
         set_form_in   = 1'b0;
         neg_in        = 1'b0;
         acc_in        = '0;
         text_ended_in = 1'b0;
         msg_len_in    = '0;
         drain_idx_in  = '0;
      end else begin
         if (cmd.load_out) begin
            drain_idx_in = drain_idx_ff + IDX_W'(1);
         end
         if (cmd.byte_en && (count_ff < CNT_W'(LINE_CHARS))) begin
            count_in = count_ff + CNT_W'(1);
            if (!text_ended_ff) begin
               if (req_rx_byte == CHAR_NUL) begin
                  text_ended_in = 1'b1;
               end else begin
                  unique case (phase_ff)
                     PH_PREFIX: begin
                        if ((count_ff < CNT_W'(4))
                            && (req_rx_byte == set_prefix_char(count_ff[1:0]))) begin
                           if (count_ff[1:0] == 2'd3) begin
                              set_form_in = 1'b1;
                              phase_in    = PH_BLANKS;
                           end
                        end else if (count_ff != '0) begin
                           phase_in = PH_FAIL;
                        end else begin
                           as_blanks = 1'b1;
                        end
                     end
                     PH_BLANKS: as_blanks = 1'b1;
                     PH_SIGN: begin
                        if (is_digit(req_rx_byte)) begin
                           phase_in = PH_DIGITS;
                           acc_in   = acc_first;
                        end else begin
                           phase_in = PH_FAIL;
                        end
                     end
                     PH_DIGITS: begin
                        if (is_digit(req_rx_byte)) begin
                           acc_in = acc_step;
                        end else begin
                           phase_in = (req_rx_byte == sep_char) ? PH_MSG : PH_FAIL;
                        end
                     end
                     PH_MSG: begin
                        if (msg_len_ff < LEN_W'(MSG_CHARS)) begin
                           mem_we     = 1'b1;
                           msg_len_in = msg_len_ff + LEN_W'(1);
                        end
                     end
                     PH_FAIL: ;
                     default: phase_in = PH_FAIL;
                  endcase
                  // Blanks, sign or first digit of the integer.
                  if (as_blanks) begin
                     if (is_blank(req_rx_byte)) begin
                        phase_in = PH_BLANKS;
                     end else if ((req_rx_byte == CHAR_PLUS)
                                  || (req_rx_byte == CHAR_MINUS)) begin
                        neg_in   = (req_rx_byte == CHAR_MINUS);
                        phase_in = PH_SIGN;
                     end else if (is_digit(req_rx_byte)) begin
                        phase_in = PH_DIGITS;
                        acc_in   = acc_first;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
               end
            end
         end
      end
   end

   // Line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         phase_ff      <= PH_PREFIX;
         set_form_ff   <= 1'b0;
         neg_ff        <= 1'b0;
         acc_ff        <= '0;
         text_ended_ff <= 1'b0;
         msg_len_ff    <= '0;
         drain_idx_ff  <= '0;
      end else begin
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         set_form_ff   <= set_form_in;
         neg_ff        <= neg_in;
         acc_ff        <= acc_in;
         text_ended_ff <= text_ended_in;
         msg_len_ff    <= msg_len_in;
         drain_idx_ff  <= drain_idx_in;
      end
   end

   // Message store write.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         msg_mem[msg_len_ff[IDX_W-1:0]] <= req_rx_byte;
      end
   end

   // Result register; the message store is read straight into it.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ok_ff       <= line_ok;
         rsp_value_ff    <= line_ok ? line_value : '0;
         rsp_msg_char_ff <= line_ok ? msg_mem[drain_idx_ff] : '0;
         rsp_last_ff     <= status.drain_last;
      end
   end

   assign rsp_ok       = rsp_ok_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_msg_char = rsp_msg_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ----- sv/serial_command_line_parser_core.sv -----
// Serial command line parser: gathers received bytes into lines and parses each
// line as "SET:<int>:<msg>" or "<int>,<msg>". A plain byte is taken with no
// stall and parsed on the fly. A line terminator (CR or LF) after a non-empty
// line holds the input stalled while the result items are loaded into the output
// register, one per cycle while the result side does not stall: one item per
// kept message character on success, a single item with ok low on failure. The
// single read port of the message store sets the pace of one character a cycle.
// An empty line gives no result.
// Depends on sclp_pkg, sclp_ctrl and sclp_datapath.
`default_nettype none

module serial_command_line_parser_core
   import sclp_pkg::*;
#(
   parameter int LINE_CHARS = LINE_CHARS_DEF,
   parameter int MSG_CHARS  = MSG_CHARS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [7:0]  req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_ok,
   output logic signed      [31:0] rsp_value,
   output logic             [7:0]  rsp_msg_char,
   output logic                    rsp_last
);

   sclp_cmd_type    cmd;
   sclp_status_type status;

   // Controller: acceptance and drain sequencing.
   sclp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: parse state, message store and result register.
   sclp_datapath #(
      .LINE_CHARS (LINE_CHARS),
      .MSG_CHARS  (MSG_CHARS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_rx_byte  (req_rx_byte),
      .cmd          (cmd),
      .status       (status),
      .rsp_ok       (rsp_ok),
      .rsp_value    (rsp_value),
      .rsp_msg_char (rsp_msg_char),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// ----- sv/sclp_checker.sv -----
// Port-level checker for the serial command line parser, bound to the top level.
// Depends on sclp_pkg and serial_command_line_parser_core_macros.svh.
`default_nettype none
`include "serial_command_line_parser_core_macros.svh"

module sclp_checker
   import sclp_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic        [7:0]  req_rx_byte,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_ok,
   input wire logic signed [31:0] rsp_value,
   input wire logic        [7:0]  rsp_msg_char,
   input wire logic               rsp_last
);

   // A stalled result item holds.
   `SCLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value) && $stable(rsp_msg_char) && $stable(rsp_last), "stalled result item changed")

   // A failure item is the only item of its line and carries zeros.
   `SCLP_ASSERT_NOW(a_fail_form, clock, reset, rsp_valid && !rsp_ok, rsp_last && (rsp_value == 32'sd0) && (rsp_msg_char == 8'd0), "malformed failure item")

   // While a line's results are still coming the input is stalled.
   `SCLP_ASSERT_NOW(a_drain_stall, clock, reset, rsp_valid && !rsp_last, rsp_ok && req_stall, "input open during result drain")

   // The next character of a line follows at once with the same value.
   `SCLP_ASSERT_NEXT(a_drain_next, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid && rsp_ok && $stable(rsp_value), "drain broke or value changed")

   // A byte that does not end a line leaves the input open for the next item.
   `SCLP_ASSERT_NEXT(a_byte_open, clock, reset, req_valid && !req_stall && (req_rx_byte != CHAR_LF) && (req_rx_byte != CHAR_CR), !req_stall, "input stalled after a plain byte")

endmodule

bind serial_command_line_parser_core sclp_checker u_sclp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_rx_byte  (req_rx_byte),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_ok       (rsp_ok),
   .rsp_value    (rsp_value),
   .rsp_msg_char (rsp_msg_char),
   .rsp_last     (rsp_last)
);

`default_nettype wire
